>>> sv/lapt_pkg.sv
`default_nettype none

package lapt_pkg;

  localparam int unsigned MAX_WAYPOINTS = 256;
  localparam int unsigned ADDR_W        = $clog2(MAX_WAYPOINTS);
  localparam int unsigned CNT_W         = ADDR_W + 1;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned DIST_W        = 31;
  localparam int unsigned SEG_W         = 8;
  localparam int unsigned DIFF_W        = COORD_W + 1;
  localparam int unsigned WP_W          = 3 * COORD_W;

  // wide datapath: holds discriminant and products with margin
  localparam int unsigned BIG_W         = 144;
  localparam int unsigned SQRT_STEPS    = 71;
  localparam int unsigned DIV_STEPS     = 112;
  localparam int unsigned STEP_W        = 7;

  localparam int unsigned JOB_W         = 4;
  localparam logic [JOB_W-1:0] JOB_C_FIRST  = 4'd0;
  localparam logic [JOB_W-1:0] JOB_K_FIRST  = 4'd3;
  localparam logic [JOB_W-1:0] JOB_A_FIRST  = 4'd6;
  localparam logic [JOB_W-1:0] JOB_RR       = 4'd9;
  localparam logic [JOB_W-1:0] JOB_KK       = 4'd10;
  localparam logic [JOB_W-1:0] JOB_CA       = 4'd11;
  localparam logic [JOB_W-1:0] JOB_PT_FIRST = 4'd12;
  localparam logic [JOB_W-1:0] JOB_PT_LAST  = 4'd14;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;
  typedef logic signed [BIG_W-1:0] big_t;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_INTERSECT = 3'd1,
    ST_END       = 3'd2,
    ST_DEVIATED  = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    E_IDLE,
    E_DIFFE,
    E_DIFFD,
    E_MSET,
    E_MNEG,
    E_MUL,
    E_MEND,
    E_CHK,
    E_SQRT,
    E_N1,
    E_N2,
    E_CMPA,
    E_CMPB,
    E_ABS,
    E_NUMER,
    E_DIV,
    E_APPLY
  } eng_state_e;

  typedef enum logic [3:0] {
    T_IDLE,
    T_EXEC,
    T_ENDCAP,
    T_RD1,
    T_RD2,
    T_RD3,
    T_SEG1,
    T_SEG2,
    T_FIN
  } top_state_e;

  typedef enum logic [2:0] {
    DST_C,
    DST_K,
    DST_A,
    DST_DS,
    DST_NUM
  } dst_e;

  typedef struct packed {
    logic done;
    logic hit;
  } eng_stat_t;

endpackage

`default_nettype wire

>>> sv/lapt_wp_ram.sv
`default_nettype none

module lapt_wp_ram (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [lapt_pkg::ADDR_W-1:0]   waddr_i,
  input  wire logic [lapt_pkg::WP_W-1:0]     wdata_i,
  input  wire logic                          re_i,
  input  wire logic [lapt_pkg::ADDR_W-1:0]   raddr_i,
  output logic      [lapt_pkg::WP_W-1:0]     rdata_o
);

  logic [lapt_pkg::WP_W-1:0] mem_q [lapt_pkg::MAX_WAYPOINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/lapt_engine.sv
`default_nettype none

module lapt_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire lapt_pkg::vec3_t               a_i,
  input  wire lapt_pkg::vec3_t               b_i,
  input  wire lapt_pkg::vec3_t               p_i,
  input  wire logic [lapt_pkg::DIST_W-1:0]   r_i,
  output lapt_pkg::eng_stat_t                stat_o,
  output lapt_pkg::vec3_t                    pt_o
);

  localparam int unsigned BW = lapt_pkg::BIG_W;

  lapt_pkg::eng_state_e state_q, state_d;
  logic [1:0] ix_q, ix_d;
  logic [lapt_pkg::JOB_W-1:0] jb_q, jb_d;
  logic [lapt_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic signed [lapt_pkg::DIFF_W-1:0] e_q [3];
  logic signed [lapt_pkg::DIFF_W-1:0] e_d [3];
  logic signed [lapt_pkg::DIFF_W-1:0] dv_q [3];
  logic signed [lapt_pkg::DIFF_W-1:0] dv_d [3];
  lapt_pkg::big_t c_q, c_d, k_q, k_d, a_q, a_d, ds_q, ds_d;
  lapt_pkg::big_t n1_q, n1_d, n2_q, n2_d;
  lapt_pkg::big_t mc_q, mc_d, mp_q, mp_d, acc_q, acc_d;
  lapt_pkg::big_t rem_q, rem_d, root_q, root_d, num_q, num_d, quo_q, quo_d;
  logic msub_q, msub_d, neg_q, neg_d, done_q, done_d, hit_q, hit_d;
  lapt_pkg::vec3_t pt_q, pt_d;

  logic [1:0] jix;
  lapt_pkg::big_t jmc, jmp, jinit;
  logic jsub;
  lapt_pkg::dst_e jdst;

  lapt_pkg::big_t opa, opb, sum;
  logic sub;
  lapt_pkg::big_t remn, trial, remd, dsor;
  logic [lapt_pkg::COORD_W-1:0] sat;

  // multiply job decode
  always_comb begin
    jix   = '0;
    jmc   = '0;
    jmp   = '0;
    jsub  = 1'b0;
    jdst  = lapt_pkg::DST_C;
    if (jb_q < lapt_pkg::JOB_K_FIRST) begin
      jix  = jb_q[1:0];
      jmc  = lapt_pkg::big_t'(e_q[jix]);
      jmp  = lapt_pkg::big_t'(e_q[jix]);
      jdst = lapt_pkg::DST_C;
    end else if (jb_q < lapt_pkg::JOB_A_FIRST) begin
      jix  = 2'(jb_q - lapt_pkg::JOB_K_FIRST);
      jmc  = lapt_pkg::big_t'(dv_q[jix]);
      jmp  = lapt_pkg::big_t'(e_q[jix]);
      jdst = lapt_pkg::DST_K;
    end else if (jb_q < lapt_pkg::JOB_RR) begin
      jix  = 2'(jb_q - lapt_pkg::JOB_A_FIRST);
      jmc  = lapt_pkg::big_t'(dv_q[jix]);
      jmp  = lapt_pkg::big_t'(dv_q[jix]);
      jdst = lapt_pkg::DST_A;
    end else if (jb_q == lapt_pkg::JOB_RR) begin
      jmc  = lapt_pkg::big_t'(r_i);
      jmp  = lapt_pkg::big_t'(r_i);
      jsub = 1'b1;
      jdst = lapt_pkg::DST_A;
    end else if (jb_q == lapt_pkg::JOB_KK) begin
      jmc  = k_q;
      jmp  = k_q;
      jdst = lapt_pkg::DST_DS;
    end else if (jb_q == lapt_pkg::JOB_CA) begin
      jmc  = c_q;
      jmp  = a_q;
      jsub = 1'b1;
      jdst = lapt_pkg::DST_DS;
    end else begin
      jix  = 2'(jb_q - lapt_pkg::JOB_PT_FIRST);
      jmc  = lapt_pkg::big_t'(e_q[jix]);
      jmp  = n1_q;
      jdst = lapt_pkg::DST_NUM;
    end
  end

  always_comb begin
    unique case (jdst)
      lapt_pkg::DST_C:  jinit = c_q;
      lapt_pkg::DST_K:  jinit = k_q;
      lapt_pkg::DST_A:  jinit = a_q;
      lapt_pkg::DST_DS: jinit = ds_q;
      default:          jinit = '0;
    endcase
  end

  assign remn  = {rem_q[BW-3:0], ds_q[2*lapt_pkg::SQRT_STEPS-1 -: 2]};
  assign trial = {root_q[BW-3:0], 2'b01};
  assign remd  = {rem_q[BW-2:0], num_q[lapt_pkg::DIV_STEPS-1]};
  assign dsor  = {c_q[BW-2:0], 1'b0};

  // shared add/subtract unit
  assign sum = opa + (sub ? ~opb : opb) + {{(BW-1){1'b0}}, sub};

  always_comb begin
    if (sum[BW-1:lapt_pkg::COORD_W-1] == '0 || sum[BW-1:lapt_pkg::COORD_W-1] == '1) begin
      sat = sum[lapt_pkg::COORD_W-1:0];
    end else if (sum[BW-1]) begin
      sat = {1'b1, {(lapt_pkg::COORD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(lapt_pkg::COORD_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    ix_d    = ix_q;
    jb_d    = jb_q;
    cnt_d   = cnt_q;
    e_d     = e_q;
    dv_d    = dv_q;
    c_d     = c_q;
    k_d     = k_q;
    a_d     = a_q;
    ds_d    = ds_q;
    n1_d    = n1_q;
    n2_d    = n2_q;
    mc_d    = mc_q;
    mp_d    = mp_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    num_d   = num_q;
    quo_d   = quo_q;
    msub_d  = msub_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    hit_d   = hit_q;
    pt_d    = pt_q;
    opa     = '0;
    opb     = '0;
    sub     = 1'b0;
    unique case (state_q)
      lapt_pkg::E_IDLE: begin
        if (start_i) begin
          c_d     = '0;
          k_d     = '0;
          a_d     = '0;
          ds_d    = '0;
          ix_d    = '0;
          state_d = lapt_pkg::E_DIFFE;
        end
      end
      lapt_pkg::E_DIFFE: begin
        opa       = lapt_pkg::big_t'($signed(b_i[ix_q]));
        opb       = lapt_pkg::big_t'($signed(a_i[ix_q]));
        sub       = 1'b1;
        e_d[ix_q] = sum[lapt_pkg::DIFF_W-1:0];
        state_d   = lapt_pkg::E_DIFFD;
      end
      lapt_pkg::E_DIFFD: begin
        opa        = lapt_pkg::big_t'($signed(a_i[ix_q]));
        opb        = lapt_pkg::big_t'($signed(p_i[ix_q]));
        sub        = 1'b1;
        dv_d[ix_q] = sum[lapt_pkg::DIFF_W-1:0];
        if (ix_q == 2'd2) begin
          jb_d    = lapt_pkg::JOB_C_FIRST;
          state_d = lapt_pkg::E_MSET;
        end else begin
          ix_d    = ix_q + 2'd1;
          state_d = lapt_pkg::E_DIFFE;
        end
      end
      lapt_pkg::E_MSET: begin
        mc_d   = jmc;
        mp_d   = jmp;
        acc_d  = jinit;
        msub_d = jsub;
        state_d = jmp[BW-1] ? lapt_pkg::E_MNEG : lapt_pkg::E_MUL;
      end
      lapt_pkg::E_MNEG: begin
        opb     = mp_q;
        sub     = 1'b1;
        mp_d    = sum;
        msub_d  = ~msub_q;
        state_d = lapt_pkg::E_MUL;
      end
      lapt_pkg::E_MUL: begin
        opa = acc_q;
        opb = mc_q;
        sub = msub_q;
        if (mp_q == '0) begin
          state_d = lapt_pkg::E_MEND;
        end else begin
          if (mp_q[0]) begin
            acc_d = sum;
          end
          mc_d = {mc_q[BW-2:0], 1'b0};
          mp_d = {1'b0, mp_q[BW-1:1]};
        end
      end
      lapt_pkg::E_MEND: begin
        unique case (jdst)
          lapt_pkg::DST_C:  c_d   = acc_q;
          lapt_pkg::DST_K:  k_d   = acc_q;
          lapt_pkg::DST_A:  a_d   = acc_q;
          lapt_pkg::DST_DS: ds_d  = acc_q;
          default:          num_d = acc_q;
        endcase
        if (jb_q == lapt_pkg::JOB_CA) begin
          state_d = lapt_pkg::E_CHK;
        end else if (jb_q >= lapt_pkg::JOB_PT_FIRST) begin
          state_d = lapt_pkg::E_ABS;
        end else begin
          jb_d    = jb_q + 1'b1;
          state_d = lapt_pkg::E_MSET;
        end
      end
      lapt_pkg::E_CHK: begin
        if (c_q == '0 || ds_q[BW-1]) begin
          done_d  = 1'b1;
          hit_d   = 1'b0;
          state_d = lapt_pkg::E_IDLE;
        end else begin
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = lapt_pkg::STEP_W'(lapt_pkg::SQRT_STEPS - 1);
          state_d = lapt_pkg::E_SQRT;
        end
      end
      lapt_pkg::E_SQRT: begin
        opa = remn;
        opb = trial;
        sub = 1'b1;
        if (!sum[BW-1]) begin
          rem_d  = sum;
          root_d = {root_q[BW-2:0], 1'b1};
        end else begin
          rem_d  = remn;
          root_d = {root_q[BW-2:0], 1'b0};
        end
        ds_d = {ds_q[BW-3:0], 2'b00};
        if (cnt_q == '0) begin
          state_d = lapt_pkg::E_N1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      lapt_pkg::E_N1: begin
        opa     = root_q;
        opb     = k_q;
        sub     = 1'b1;
        n1_d    = sum;
        state_d = lapt_pkg::E_N2;
      end
      lapt_pkg::E_N2: begin
        opa  = n1_q;
        opb  = {root_q[BW-2:0], 1'b0};
        sub  = 1'b1;
        n2_d = sum;
        if (n1_q[BW-1]) begin
          done_d  = 1'b1;
          hit_d   = 1'b0;
          state_d = lapt_pkg::E_IDLE;
        end else begin
          state_d = lapt_pkg::E_CMPA;
        end
      end
      lapt_pkg::E_CMPA: begin
        opa = c_q;
        opb = n2_q;
        sub = 1'b1;
        if (sum[BW-1]) begin
          done_d  = 1'b1;
          hit_d   = 1'b0;
          state_d = lapt_pkg::E_IDLE;
        end else begin
          state_d = lapt_pkg::E_CMPB;
        end
      end
      lapt_pkg::E_CMPB: begin
        opa = c_q;
        opb = n1_q;
        sub = 1'b1;
        if (sum[BW-1] && n2_q[BW-1]) begin
          done_d  = 1'b1;
          hit_d   = 1'b0;
          state_d = lapt_pkg::E_IDLE;
        end else begin
          jb_d    = lapt_pkg::JOB_PT_FIRST;
          state_d = lapt_pkg::E_MSET;
        end
      end
      lapt_pkg::E_ABS: begin
        opb   = num_q;
        sub   = 1'b1;
        neg_d = num_q[BW-1];
        if (num_q[BW-1]) begin
          num_d = sum;
        end
        state_d = lapt_pkg::E_NUMER;
      end
      lapt_pkg::E_NUMER: begin
        opa     = {num_q[BW-2:0], 1'b0};
        opb     = c_q;
        num_d   = sum;
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = lapt_pkg::STEP_W'(lapt_pkg::DIV_STEPS - 1);
        state_d = lapt_pkg::E_DIV;
      end
      lapt_pkg::E_DIV: begin
        opa = remd;
        opb = dsor;
        sub = 1'b1;
        if (!sum[BW-1]) begin
          rem_d = sum;
          quo_d = {quo_q[BW-2:0], 1'b1};
        end else begin
          rem_d = remd;
          quo_d = {quo_q[BW-2:0], 1'b0};
        end
        num_d = {num_q[BW-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = lapt_pkg::E_APPLY;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      lapt_pkg::E_APPLY: begin
        opa       = lapt_pkg::big_t'($signed(a_i[jix]));
        opb       = quo_q;
        sub       = neg_q;
        pt_d[jix] = sat;
        if (jb_q == lapt_pkg::JOB_PT_LAST) begin
          done_d  = 1'b1;
          hit_d   = 1'b1;
          state_d = lapt_pkg::E_IDLE;
        end else begin
          jb_d    = jb_q + 1'b1;
          state_d = lapt_pkg::E_MSET;
        end
      end
      default: begin
        state_d = lapt_pkg::E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lapt_pkg::E_IDLE;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ix_q   <= ix_d;
    jb_q   <= jb_d;
    cnt_q  <= cnt_d;
    e_q    <= e_d;
    dv_q   <= dv_d;
    c_q    <= c_d;
    k_q    <= k_d;
    a_q    <= a_d;
    ds_q   <= ds_d;
    n1_q   <= n1_d;
    n2_q   <= n2_d;
    mc_q   <= mc_d;
    mp_q   <= mp_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    msub_q <= msub_d;
    neg_q  <= neg_d;
    pt_q   <= pt_d;
  end

  assign stat_o = '{done: done_q, hit: hit_q};
  assign pt_o   = pt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == lapt_pkg::E_IDLE)
    else $error("engine started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lapt_pkg::E_MUL |-> !mp_q[BW-1])
    else $error("multiplier operand negative during shift-add");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lapt_pkg::E_DIV || state_q == lapt_pkg::E_SQRT) |-> !rem_q[BW-1])
    else $error("negative partial remainder");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == lapt_pkg::E_IDLE)
    else $error("done raised while engine busy");

endmodule

`default_nettype wire

>>> sv/lookahead_point_tracker.sv
`default_nettype none

// Pure-pursuit lookahead point on a 3D waypoint path (signed Q16.16). Clear,
// append and ignored requests go straight from execution to the result; an
// end-of-path query on a non-empty path first reads the last waypoint. A
// lookahead query reads three waypoints and then runs one shared 144-bit
// add/subtract unit for the sphere test: shift-add multiplies (one multiplier
// bit a cycle), a 71-step square root and three 112-step divisions. The
// segment after the current one is tried first, and the current one only if
// that misses. One item is in flight at a time; a finished result waits in
// the output register while the next item is taken.

module lookahead_point_tracker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic signed [lapt_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic signed [lapt_pkg::COORD_W-1:0] coord_y_i,
  input  wire logic signed [lapt_pkg::COORD_W-1:0] coord_z_i,
  input  wire logic [lapt_pkg::DIST_W-1:0]       lookahead_dist_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [2:0]                             status_o,
  output logic signed [lapt_pkg::COORD_W-1:0]    point_x_o,
  output logic signed [lapt_pkg::COORD_W-1:0]    point_y_o,
  output logic signed [lapt_pkg::COORD_W-1:0]    point_z_o,
  output logic [lapt_pkg::SEG_W-1:0]             seg_index_o
);

  lapt_pkg::top_state_e state_q, state_d;
  logic [lapt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [lapt_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic [1:0] req_q;
  lapt_pkg::vec3_t pos_q, w0_q, w1_q, w2_q;
  logic [lapt_pkg::DIST_W-1:0] rad_q;
  logic sel_q, sel_d;
  logic [2:0] res_status_q, res_status_d;
  lapt_pkg::vec3_t res_pt_q, res_pt_d;
  logic out_valid_q, out_valid_d;
  logic [2:0] out_status_q;
  lapt_pkg::vec3_t out_pt_q;
  logic [lapt_pkg::SEG_W-1:0] out_seg_q;

  logic in_acc, out_load;
  logic we, re, eng_start;
  logic [lapt_pkg::ADDR_W-1:0] raddr;
  logic [lapt_pkg::WP_W-1:0] rdata;
  lapt_pkg::eng_stat_t eng_stat;
  lapt_pkg::vec3_t eng_pt, eng_a, eng_b;

  assign in_ready_o = (state_q == lapt_pkg::T_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  lapt_wp_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[lapt_pkg::ADDR_W-1:0]),
    .wdata_i (pos_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign eng_a = sel_q ? w0_q : w1_q;
  assign eng_b = sel_q ? w1_q : w2_q;

  lapt_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eng_start),
    .a_i     (eng_a),
    .b_i     (eng_b),
    .p_i     (pos_q),
    .r_i     (rad_q),
    .stat_o  (eng_stat),
    .pt_o    (eng_pt)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    sel_d        = sel_q;
    res_status_d = res_status_q;
    res_pt_d     = res_pt_q;
    we           = 1'b0;
    re           = 1'b0;
    raddr        = idx_q;
    eng_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      lapt_pkg::T_IDLE: begin
        if (in_acc) begin
          state_d = lapt_pkg::T_EXEC;
        end
      end
      lapt_pkg::T_EXEC: begin
        res_status_d = lapt_pkg::ST_ACCEPTED;
        res_pt_d     = '0;
        state_d      = lapt_pkg::T_FIN;
        unique case (req_q)
          lapt_pkg::REQ_CLEAR: begin
            cnt_d = '0;
            idx_d = '0;
          end
          lapt_pkg::REQ_APPEND: begin
            if (cnt_q == lapt_pkg::CNT_W'(lapt_pkg::MAX_WAYPOINTS)) begin
              res_status_d = lapt_pkg::ST_FULL;
            end else begin
              we    = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end
          end
          lapt_pkg::REQ_QUERY: begin
            if ((lapt_pkg::CNT_W'(idx_q) + lapt_pkg::CNT_W'(2)) >= cnt_q) begin
              res_status_d = lapt_pkg::ST_END;
              if (cnt_q != '0) begin
                re      = 1'b1;
                raddr   = lapt_pkg::ADDR_W'(cnt_q - 1'b1);
                state_d = lapt_pkg::T_ENDCAP;
              end
            end else begin
              re      = 1'b1;
              sel_d   = 1'b0;
              state_d = lapt_pkg::T_RD1;
            end
          end
          default: begin
          end
        endcase
      end
      lapt_pkg::T_ENDCAP: begin
        res_pt_d = rdata;
        state_d  = lapt_pkg::T_FIN;
      end
      lapt_pkg::T_RD1: begin
        re      = 1'b1;
        raddr   = idx_q + lapt_pkg::ADDR_W'(1);
        state_d = lapt_pkg::T_RD2;
      end
      lapt_pkg::T_RD2: begin
        re      = 1'b1;
        raddr   = idx_q + lapt_pkg::ADDR_W'(2);
        state_d = lapt_pkg::T_RD3;
      end
      lapt_pkg::T_RD3: begin
        eng_start = 1'b1;
        state_d   = lapt_pkg::T_SEG1;
      end
      lapt_pkg::T_SEG1: begin
        if (eng_stat.done) begin
          if (eng_stat.hit) begin
            idx_d        = idx_q + 1'b1;
            res_status_d = lapt_pkg::ST_INTERSECT;
            res_pt_d     = eng_pt;
            state_d      = lapt_pkg::T_FIN;
          end else begin
            sel_d     = 1'b1;
            eng_start = 1'b1;
            state_d   = lapt_pkg::T_SEG2;
          end
        end
      end
      lapt_pkg::T_SEG2: begin
        if (eng_stat.done) begin
          if (eng_stat.hit) begin
            res_status_d = lapt_pkg::ST_INTERSECT;
            res_pt_d     = eng_pt;
          end else begin
            res_status_d = lapt_pkg::ST_DEVIATED;
            res_pt_d     = '0;
          end
          state_d = lapt_pkg::T_FIN;
        end
      end
      lapt_pkg::T_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = lapt_pkg::T_IDLE;
        end
      end
      default: begin
        state_d = lapt_pkg::T_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lapt_pkg::T_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q        <= sel_d;
    res_status_q <= res_status_d;
    res_pt_q     <= res_pt_d;
    if (in_acc) begin
      req_q <= req_type_i;
      pos_q <= {coord_z_i, coord_y_i, coord_x_i};
      rad_q <= lookahead_dist_i;
    end
    if (state_q == lapt_pkg::T_RD1) begin
      w0_q <= rdata;
    end
    if (state_q == lapt_pkg::T_RD2) begin
      w1_q <= rdata;
    end
    if (state_q == lapt_pkg::T_RD3) begin
      w2_q <= rdata;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pt_q     <= res_pt_q;
      out_seg_q    <= lapt_pkg::SEG_W'(idx_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign point_x_o   = out_pt_q[0];
  assign point_y_o   = out_pt_q[1];
  assign point_z_o   = out_pt_q[2];
  assign seg_index_o = out_seg_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lapt_pkg::CNT_W'(lapt_pkg::MAX_WAYPOINTS))
    else $error("waypoint count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q == '0 || lapt_pkg::CNT_W'(idx_q) < cnt_q)
    else $error("segment index past last waypoint");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.done |-> (state_q == lapt_pkg::T_SEG1 || state_q == lapt_pkg::T_SEG2))
    else $error("engine finished outside a segment test");

endmodule

`default_nettype wire
